FILE: rtl/acc_pkg.sv
// package: payload structs, register indexes and reset values for the box cull block
package acc_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CFG_REGS       = 8;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int ENTRY_BITS     = 32;
  localparam int TAG_BITS       = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROW0_C01 = 3'd0,
    REG_ROW0_C23 = 3'd1,
    REG_ROW1_C01 = 3'd2,
    REG_ROW1_C23 = 3'd3,
    REG_ROW2_C01 = 3'd4,
    REG_ROW2_C23 = 3'd5,
    REG_ROW3_C01 = 3'd6,
    REG_ROW3_C23 = 3'd7
  } cfg_reg_t;

  localparam logic [CFG_DATA_BITS-1:0] RESET_ROW0_C01 = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_BITS-1:0] RESET_ROW0_C23 = 64'h0;
  localparam logic [CFG_DATA_BITS-1:0] RESET_ROW1_C01 = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_BITS-1:0] RESET_ROW1_C23 = 64'h0;
  localparam logic [CFG_DATA_BITS-1:0] RESET_ROW2_C01 = 64'h0;
  localparam logic [CFG_DATA_BITS-1:0] RESET_ROW2_C23 = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_BITS-1:0] RESET_ROW3_C01 = 64'h0;
  localparam logic [CFG_DATA_BITS-1:0] RESET_ROW3_C23 = 64'h0001_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] bounds_min_x;
    logic signed [31:0] bounds_min_y;
    logic signed [31:0] bounds_min_z;
    logic signed [31:0] bounds_max_x;
    logic signed [31:0] bounds_max_y;
    logic signed [31:0] bounds_max_z;
    logic [TAG_BITS-1:0] item_tag;
  } box_in_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] result_tag;
    logic                visible;
  } cull_out_t;

  // pipeline control shared between stages
  typedef struct packed {
    logic advance;
    logic busy;
  } pipe_ctrl_t;

endpackage

FILE: rtl/acc_matrix_regs.sv
// configuration registers holding the 4x4 view-projection matrix
module acc_matrix_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [acc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [acc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  output logic [acc_pkg::ENTRY_BITS-1:0]        entry [4][4]
);

  logic [acc_pkg::CFG_DATA_BITS-1:0] regs [acc_pkg::CFG_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[acc_pkg::REG_ROW0_C01] <= acc_pkg::RESET_ROW0_C01;
      regs[acc_pkg::REG_ROW0_C23] <= acc_pkg::RESET_ROW0_C23;
      regs[acc_pkg::REG_ROW1_C01] <= acc_pkg::RESET_ROW1_C01;
      regs[acc_pkg::REG_ROW1_C23] <= acc_pkg::RESET_ROW1_C23;
      regs[acc_pkg::REG_ROW2_C01] <= acc_pkg::RESET_ROW2_C01;
      regs[acc_pkg::REG_ROW2_C23] <= acc_pkg::RESET_ROW2_C23;
      regs[acc_pkg::REG_ROW3_C01] <= acc_pkg::RESET_ROW3_C01;
      regs[acc_pkg::REG_ROW3_C23] <= acc_pkg::RESET_ROW3_C23;
    end else if (cfg_write) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      entry[r][0] = regs[2*r][31:0];
      entry[r][1] = regs[2*r][63:32];
      entry[r][2] = regs[2*r+1][31:0];
      entry[r][3] = regs[2*r+1][63:32];
    end
  end

endmodule

FILE: rtl/acc_transform.sv
// stages 1-3: per-axis products, corner sums and plane tests
// clip is linear, so each axis contributes either lo*M or hi*M; 24 products
module acc_transform #(
  parameter int COORD_BITS = acc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = acc_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  acc_pkg::pipe_ctrl_t             ctrl,
  input  logic                            in_valid,
  input  acc_pkg::box_in_t                in_box,
  input  logic [acc_pkg::ENTRY_BITS-1:0]  entry [4][4],
  output logic                            out_valid,
  output acc_pkg::cull_out_t              out_item
);

  localparam int PROD_BITS = COORD_BITS + acc_pkg::ENTRY_BITS;
  localparam int SUM_BITS  = PROD_BITS + 4;

  // coordinates narrowed to COORD_BITS (low bits kept); sign-extended when cast for the products
  logic signed [COORD_BITS-1:0] lo [3];
  logic signed [COORD_BITS-1:0] hi [3];

  always_comb begin
    lo[0] = in_box.bounds_min_x[COORD_BITS-1:0];
    lo[1] = in_box.bounds_min_y[COORD_BITS-1:0];
    lo[2] = in_box.bounds_min_z[COORD_BITS-1:0];
    hi[0] = in_box.bounds_max_x[COORD_BITS-1:0];
    hi[1] = in_box.bounds_max_y[COORD_BITS-1:0];
    hi[2] = in_box.bounds_max_z[COORD_BITS-1:0];
  end

  // stage 1: products
  logic signed [PROD_BITS-1:0] p_lo [3][4];
  logic signed [PROD_BITS-1:0] p_hi [3][4];
  logic signed [PROD_BITS-1:0] p_tr [4];
  logic [acc_pkg::TAG_BITS-1:0] tag1, tag2, tag3;
  logic v1, v2, v3;

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      for (int a = 0; a < 3; a++) begin
        for (int c = 0; c < 4; c++) begin
          p_lo[a][c] <= PROD_BITS'(lo[a]) * PROD_BITS'($signed(entry[a][c]));
          p_hi[a][c] <= PROD_BITS'(hi[a]) * PROD_BITS'($signed(entry[a][c]));
        end
      end
      for (int c = 0; c < 4; c++) begin
        p_tr[c] <= PROD_BITS'($signed(entry[3][c])) <<< FRAC_BITS;
      end
      tag1 <= in_box.item_tag;
    end
  end

  // stage 2: eight corner sums per column
  logic signed [SUM_BITS-1:0] clip [8][4];

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      for (int k = 0; k < 8; k++) begin
        for (int c = 0; c < 4; c++) begin
          clip[k][c] <= SUM_BITS'(p_tr[c])
                      + SUM_BITS'(k[2] ? p_hi[0][c] : p_lo[0][c])
                      + SUM_BITS'(k[1] ? p_hi[1][c] : p_lo[1][c])
                      + SUM_BITS'(k[0] ? p_hi[2][c] : p_lo[2][c]);
        end
      end
      tag2 <= tag1;
    end
  end

  // stage 3: plane tests, then and across corners
  logic [5:0] all_out;
  logic [5:0] outs [8];
  logic signed [SUM_BITS:0] t0, t1, t2, t3, t5;

  always_comb begin
    t0 = '0; t1 = '0; t2 = '0; t3 = '0; t5 = '0;
    for (int k = 0; k < 8; k++) begin
      t0 = (SUM_BITS+1)'(clip[k][0]) + (SUM_BITS+1)'(clip[k][3]);
      t1 = (SUM_BITS+1)'(clip[k][3]) - (SUM_BITS+1)'(clip[k][0]);
      t2 = (SUM_BITS+1)'(clip[k][1]) + (SUM_BITS+1)'(clip[k][3]);
      t3 = (SUM_BITS+1)'(clip[k][3]) - (SUM_BITS+1)'(clip[k][1]);
      t5 = (SUM_BITS+1)'(clip[k][3]) - (SUM_BITS+1)'(clip[k][2]);
      outs[k] = {t5[SUM_BITS], clip[k][2][SUM_BITS-1], t3[SUM_BITS],
                 t2[SUM_BITS], t1[SUM_BITS], t0[SUM_BITS]};
    end
    all_out = '1;
    for (int k = 0; k < 8; k++) begin
      all_out = all_out & outs[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      tag3 <= tag2;
      out_item.result_tag <= tag2;
      out_item.visible    <= ~(|all_out);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (ctrl.advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign out_valid = v3;

`ifndef ASSERT_OFF
  a_tag_follow: assert property (@(posedge clk) disable iff (rst)
    ctrl.advance && v2 |=> out_item.result_tag == tag3)
    else $error("result tag not carried with its item");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !ctrl.advance |=> $stable(v3) && $stable(out_item))
    else $error("last stage changed while stalled");
  a_valid_chain: assert property (@(posedge clk) disable iff (rst)
    ctrl.advance && v2 |=> v3)
    else $error("item lost between stages");
`endif

endmodule

FILE: rtl/aabb_clip_volume_cull.sv
// top level: box clip-volume culling pipeline
// usage:
//   input channel in_valid/in_stall carries one box (min/max corner in signed
//   fixed point plus a tag); a transfer happens when in_valid is high and
//   in_stall low. the output channel out_valid/out_stall returns the tag and
//   a visible flag, one result per box, in order.
//   the matrix is written through cfg_write/cfg_index/cfg_data, one 64-bit
//   register (two 32-bit entries) per write; write only while the block is
//   empty. every 3-bit index names one of the eight registers.
// output: the result and out_valid come from the third stage's registers.
// throughput: one box per cycle unless stalled; the three stages (24
//   multipliers, corner adders, plane compares) all advance together.
// reset: rst is synchronous; it empties the pipeline and loads the identity
//   matrix.
// stall: when out_stall is high with a result waiting, the whole pipeline
//   holds and in_stall rises; nothing is dropped or repeated.
module aabb_clip_volume_cull #(
  parameter int COORD_BITS = acc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = acc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  acc_pkg::box_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output acc_pkg::cull_out_t                out_data,
  input  logic                              cfg_write,
  input  logic [acc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [acc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  logic [acc_pkg::ENTRY_BITS-1:0] entry [4][4];
  acc_pkg::pipe_ctrl_t ctrl;

  always_comb begin
    ctrl.busy    = out_valid & out_stall;
    ctrl.advance = ~ctrl.busy;
  end

  assign in_stall = ctrl.busy;

  acc_matrix_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .entry     (entry)
  );

  acc_transform #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_xform (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_valid  (in_valid),
    .in_box    (in_data),
    .entry     (entry),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

`ifndef ASSERT_OFF
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no waiting result");
`endif

endmodule
